[rtl/ppd_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package ppd_pkg;

    typedef struct packed {
        logic        kind;
        logic [31:0] capture_time;
        logic        fix_valid;
    } t_in;

    typedef struct packed {
        logic signed [31:0] phase_error;
        logic [15:0]        coarse_duty;
        logic [15:0]        fine_duty;
        logic signed [39:0] integral;
        logic               duty_updated;
        logic               lock_lost;
    } t_out;

    localparam int CFG_DATA_W = 40;

    typedef enum logic [2:0] {
        CFG_INITIAL_DUTY     = 3'd0,
        CFG_INITIAL_INTEGRAL = 3'd1,
        CFG_PROP_GAIN        = 3'd2,
        CFG_INTEGRAL_GAIN    = 3'd3,
        CFG_CAPTURE_MODULUS  = 3'd4,
        CFG_PHASE_LIMIT      = 3'd5,
        CFG_STRIKE_RELOAD    = 3'd6,
        CFG_FINE_SCALE       = 3'd7
    } t_cfg_idx;

    localparam logic KIND_OSC = 1'b0;
    localparam logic KIND_REF = 1'b1;

    localparam logic [15:0]        RST_INITIAL_DUTY     = 16'd32768;
    localparam logic signed [39:0] RST_INITIAL_INTEGRAL = 40'sd0;
    localparam logic [31:0]        RST_PROP_GAIN        = 32'd281474977;
    localparam logic [31:0]        RST_INTEGRAL_GAIN    = 32'd211106;
    localparam logic [30:0]        RST_CAPTURE_MODULUS  = 31'd100000000;
    localparam logic [30:0]        RST_PHASE_LIMIT      = 31'd100000;
    localparam logic [3:0]         RST_STRIKE_RELOAD    = 4'd3;
    localparam logic [7:0]         RST_FINE_SCALE       = 8'd121;

    localparam logic [15:0] FINE_ROUND = 16'h0180;
    localparam logic [15:0] FINE_MASK  = 16'hFF00;

    typedef enum logic [1:0] {
        MUL_NONE,
        MUL_ERR,
        MUL_LO,
        MUL_HI
    } t_mul_sel;

    typedef enum logic [1:0] {
        ACC_NONE,
        ACC_LOAD,
        ACC_ADD,
        ACC_ADD_HI
    } t_acc_op;

    typedef struct packed {
        logic     accept;
        logic     diff;
        logic     fold_lo;
        logic     fold_hi;
        logic     judge;
        logic     integ;
        t_mul_sel mul_sel;
        t_acc_op  acc_op;
        logic     clamp;
        logic     duty;
        logic     out_load;
    } t_cmd;

    typedef struct packed {
        logic fix;
        logic oversize;
    } t_sts;

endpackage

`default_nettype wire

[rtl/ppd_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none

module ppd_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    input  wire logic          i_in_kind,
    output logic               o_in_stall,
    output logic               o_out_valid,
    input  wire logic          i_out_stall,
    input  ppd_pkg::t_sts      i_sts,
    output ppd_pkg::t_cmd      o_cmd
);
    import ppd_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIFF,
        ST_FOLD_LO,
        ST_FOLD_HI,
        ST_JUDGE,
        ST_INTEG,
        ST_MUL_ERR,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_ACC_HI,
        ST_CLAMP,
        ST_DUTY,
        ST_DONE
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid & i_out_stall;
        o_cmd       = '0;
        o_cmd.mul_sel = MUL_NONE;
        o_cmd.acc_op  = ACC_NONE;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    if (i_in_kind == KIND_REF) begin
                        n_state = ST_DIFF;
                    end
                end
            end
            ST_DIFF: begin
                o_cmd.diff = 1'b1;
                n_state    = ST_FOLD_LO;
            end
            ST_FOLD_LO: begin
                o_cmd.fold_lo = 1'b1;
                n_state       = ST_FOLD_HI;
            end
            ST_FOLD_HI: begin
                o_cmd.fold_hi = 1'b1;
                n_state       = ST_JUDGE;
            end
            ST_JUDGE: begin
                o_cmd.judge = 1'b1;
                if (i_sts.fix && !i_sts.oversize) begin
                    n_state = ST_INTEG;
                end else begin
                    n_state = ST_DONE;
                end
            end
            ST_INTEG: begin
                o_cmd.integ = 1'b1;
                n_state     = ST_MUL_ERR;
            end
            ST_MUL_ERR: begin
                o_cmd.mul_sel = MUL_ERR;
                n_state       = ST_MUL_LO;
            end
            ST_MUL_LO: begin
                o_cmd.mul_sel = MUL_LO;
                o_cmd.acc_op  = ACC_LOAD;
                n_state       = ST_MUL_HI;
            end
            ST_MUL_HI: begin
                o_cmd.mul_sel = MUL_HI;
                o_cmd.acc_op  = ACC_ADD;
                n_state       = ST_ACC_HI;
            end
            ST_ACC_HI: begin
                o_cmd.acc_op = ACC_ADD_HI;
                n_state      = ST_CLAMP;
            end
            ST_CLAMP: begin
                o_cmd.clamp = 1'b1;
                n_state     = ST_DUTY;
            end
            ST_DUTY: begin
                o_cmd.duty = 1'b1;
                n_state    = ST_DONE;
            end
            ST_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

[rtl/ppd_dp.sv]
`timescale 1ns / 1ps
`default_nettype none

module ppd_dp #(
    parameter int INTEGRATOR_WIDTH = 40
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  ppd_pkg::t_cmd                      i_cmd,
    output ppd_pkg::t_sts                      o_sts,
    input  ppd_pkg::t_in                       i_in_data,
    input  wire logic                          i_cfg_valid,
    input  ppd_pkg::t_cfg_idx                  i_cfg_index,
    input  wire logic [ppd_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output ppd_pkg::t_out                      o_out_data
);
    import ppd_pkg::*;

    localparam int IW = INTEGRATOR_WIDTH;
    localparam int RW = (IW > 40) ? IW : 40;
    localparam int AW = RW + 1;
    localparam int SW = IW + 34;
    localparam int DW = SW - 16;
    localparam int EW = 34;

    logic [15:0]        r_init_duty;
    logic signed [39:0] r_init_integ;
    logic [31:0]        r_prop_gain;
    logic [31:0]        r_integ_gain;
    logic [30:0]        r_modulus;
    logic [30:0]        r_limit;
    logic [3:0]         r_reload;
    logic [7:0]         r_fine_scale;

    logic               r_kind_unused_guard;
    logic [31:0]        r_cap;
    logic               r_fix;
    logic [31:0]        r_osc_cap;
    logic               r_osc_seen;
    logic signed [EW-1:0] r_err;
    logic signed [IW-1:0] r_integ;
    logic [3:0]         r_strikes;
    logic [15:0]        r_coarse;
    logic [15:0]        r_fine;
    logic               r_updated;
    logic               r_lost;
    logic signed [65:0] r_prod;
    logic signed [SW-1:0] r_acc;
    logic [32:0]        r_dq;
    t_out               r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_init_duty  <= RST_INITIAL_DUTY;
            r_init_integ <= RST_INITIAL_INTEGRAL;
            r_prop_gain  <= RST_PROP_GAIN;
            r_integ_gain <= RST_INTEGRAL_GAIN;
            r_modulus    <= RST_CAPTURE_MODULUS;
            r_limit      <= RST_PHASE_LIMIT;
            r_reload     <= RST_STRIKE_RELOAD;
            r_fine_scale <= RST_FINE_SCALE;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_INITIAL_DUTY:     r_init_duty  <= i_cfg_data[15:0];
                CFG_INITIAL_INTEGRAL: r_init_integ <= $signed(i_cfg_data[39:0]);
                CFG_PROP_GAIN:        r_prop_gain  <= i_cfg_data[31:0];
                CFG_INTEGRAL_GAIN:    r_integ_gain <= i_cfg_data[31:0];
                CFG_CAPTURE_MODULUS:  r_modulus    <= i_cfg_data[30:0];
                CFG_PHASE_LIMIT:      r_limit      <= i_cfg_data[30:0];
                CFG_STRIKE_RELOAD:    r_reload     <= i_cfg_data[3:0];
                CFG_FINE_SCALE:       r_fine_scale <= i_cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

    logic signed [RW-1:0] init_ext;
    logic                 init_fits;
    logic signed [IW-1:0] init_load;

    assign init_ext  = RW'(r_init_integ);
    assign init_fits = (&init_ext[RW-1:IW-1]) | ~(|init_ext[RW-1:IW-1]);
    assign init_load = init_fits ? init_ext[IW-1:0]
                     : (init_ext[RW-1] ? $signed({1'b1, {(IW-1){1'b0}}})
                                       : $signed({1'b0, {(IW-1){1'b1}}}));

    logic [31:0]          diff32;
    logic signed [EW-1:0] err_raw;
    logic signed [EW-1:0] half_s;
    logic signed [EW-1:0] mod_s;
    logic signed [EW-1:0] mag;
    logic                 oversize;

    assign diff32   = r_osc_cap - r_cap;
    assign err_raw  = r_osc_seen ? EW'($signed(diff32)) : '0;
    assign half_s   = $signed({4'b0, r_modulus[30:1]});
    assign mod_s    = $signed({3'b0, r_modulus});
    assign mag      = r_err[EW-1] ? -r_err : r_err;
    assign oversize = (mag > $signed({3'b0, r_limit}));

    logic signed [AW-1:0] integ_sum;
    logic                 sum_fits;
    logic signed [IW-1:0] integ_next;

    assign integ_sum  = AW'(r_integ) + AW'(r_err);
    assign sum_fits   = (&integ_sum[AW-1:IW-1]) | ~(|integ_sum[AW-1:IW-1]);
    assign integ_next = sum_fits ? integ_sum[IW-1:0]
                      : (integ_sum[AW-1] ? $signed({1'b1, {(IW-1){1'b0}}})
                                         : $signed({1'b0, {(IW-1){1'b1}}}));

    logic signed [63:0] integ64;
    logic signed [32:0] mul_a;
    logic signed [32:0] mul_b;

    assign integ64 = 64'(r_integ);

    always_comb begin
        case (i_cmd.mul_sel)
            MUL_ERR: begin
                mul_a = r_err[32:0];
                mul_b = $signed({1'b0, r_prop_gain});
            end
            MUL_LO: begin
                mul_a = $signed({1'b0, integ64[31:0]});
                mul_b = $signed({1'b0, r_integ_gain});
            end
            MUL_HI: begin
                mul_a = $signed({integ64[63], integ64[63:32]});
                mul_b = $signed({1'b0, r_integ_gain});
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    logic signed [SW-1:0] prod_sx;
    logic signed [SW-1:0] prod_hi;

    assign prod_sx = SW'(r_prod);
    assign prod_hi = $signed({prod_sx[SW-33:0], 32'd0});

    logic signed [DW-1:0] d_sum;
    logic                 d_over;

    assign d_sum  = $signed(r_acc[SW-1:16])
                  + $signed({{(DW-32){1'b0}}, 32'h8000_0000});
    assign d_over = (|d_sum[DW-2:33]) | (d_sum[32] & (|d_sum[31:0]));

    logic [23:0] fine_prod;
    logic [15:0] fine_next;
    logic [15:0] coarse_next;

    assign fine_prod   = 24'(r_dq[15:0]) * 24'(r_fine_scale);
    assign fine_next   = ({fine_prod[23:16], 8'h00} + FINE_ROUND) & FINE_MASK;
    assign coarse_next = r_dq[32] ? 16'hFFFF : r_dq[31:16];

    logic signed [RW-1:0] rep_ext;
    logic                 rep_fits;
    logic signed [39:0]   rep;

    assign rep_ext  = RW'(r_integ);
    assign rep_fits = (&rep_ext[RW-1:39]) | ~(|rep_ext[RW-1:39]);
    assign rep      = rep_fits ? rep_ext[39:0]
                    : (rep_ext[RW-1] ? 40'sh80_0000_0000 : 40'sh7F_FFFF_FFFF);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_osc_seen <= 1'b0;
            r_osc_cap  <= '0;
            r_integ    <= '0;
            r_strikes  <= RST_STRIKE_RELOAD;
            r_coarse   <= RST_INITIAL_DUTY;
            r_fine     <= '0;
            r_updated  <= 1'b0;
            r_lost     <= 1'b0;
        end else begin
            if (i_cmd.accept) begin
                r_updated <= 1'b0;
                r_lost    <= 1'b0;
                if (i_in_data.kind == KIND_OSC) begin
                    r_osc_cap  <= i_in_data.capture_time;
                    r_osc_seen <= 1'b1;
                end
            end
            if (i_cmd.judge && r_fix) begin
                if (oversize) begin
                    if (r_strikes == 4'd0) begin
                        r_integ    <= init_load;
                        r_strikes  <= r_reload;
                        r_coarse   <= r_init_duty;
                        r_fine     <= '0;
                        r_osc_seen <= 1'b0;
                        r_lost     <= 1'b1;
                    end else begin
                        r_strikes <= r_strikes - 4'd1;
                    end
                end else begin
                    r_strikes <= r_reload;
                end
            end
            if (i_cmd.integ) begin
                r_integ <= integ_next;
            end
            if (i_cmd.duty) begin
                r_coarse  <= coarse_next;
                r_fine    <= fine_next;
                r_updated <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_cap <= i_in_data.capture_time;
            r_fix <= i_in_data.fix_valid;
        end
        if (i_cmd.diff) begin
            r_err <= err_raw;
        end else if (i_cmd.fold_lo) begin
            if (r_err < -half_s) begin
                r_err <= r_err + mod_s;
            end
        end else if (i_cmd.fold_hi) begin
            if (r_err > half_s) begin
                r_err <= r_err - mod_s;
            end
        end
        if (i_cmd.mul_sel != MUL_NONE) begin
            r_prod <= mul_a * mul_b;
        end
        case (i_cmd.acc_op)
            ACC_LOAD:   r_acc <= prod_sx;
            ACC_ADD:    r_acc <= r_acc + prod_sx;
            ACC_ADD_HI: r_acc <= r_acc + prod_hi;
            default: begin
            end
        endcase
        if (i_cmd.clamp) begin
            if (d_sum[DW-1]) begin
                r_dq <= '0;
            end else if (d_over) begin
                r_dq <= {1'b1, 32'd0};
            end else begin
                r_dq <= d_sum[32:0];
            end
        end
        if (i_cmd.out_load) begin
            r_out.phase_error  <= r_err[31:0];
            r_out.coarse_duty  <= r_coarse;
            r_out.fine_duty    <= r_fine;
            r_out.integral     <= rep;
            r_out.duty_updated <= r_updated;
            r_out.lock_lost    <= r_lost;
        end
    end

    assign r_kind_unused_guard = 1'b0;
    assign o_sts.fix      = r_fix | r_kind_unused_guard;
    assign o_sts.oversize = oversize;
    assign o_out_data     = r_out;

endmodule

`default_nettype wire

[rtl/pps_phase_pi_discipliner.sv]
// Oscillator capture: taken while idle, no result; the next item may follow at once.
// Reference capture: steps diff, fold low, fold high and judge; on a loop update it
// also steps integrate, then three multiply steps (error, integral low and high) on
// one shared 33x33 signed multiplier, accumulate high, clamp and duty; then done
// registers the result once the output is not stalled. Input stalls until idle again.
// Synchronous active-low reset loads register defaults and the initial loop state.
`timescale 1ns / 1ps
`default_nettype none

module pps_phase_pi_discipliner #(
    parameter int INTEGRATOR_WIDTH = 40
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_in_valid,
    input  ppd_pkg::t_in                        i_in_data,
    output logic                                o_in_stall,
    output logic                                o_out_valid,
    output ppd_pkg::t_out                       o_out_data,
    input  wire logic                           i_out_stall,
    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  ppd_pkg::t_cfg_idx                   i_cfg_index,
    input  wire logic [ppd_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import ppd_pkg::*;

    t_cmd cmd;
    t_sts sts;

    ppd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_kind   (i_in_data.kind),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    ppd_dp #(
        .INTEGRATOR_WIDTH (INTEGRATOR_WIDTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_in_data   (i_in_data),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_out_data  (o_out_data)
    );

    assign o_cfg_ready = 1'b1;

endmodule

`default_nettype wire

[rtl/ppd_chk.sv]
`timescale 1ns / 1ps
`default_nettype none

module ppd_chk (
    input wire logic          i_clk,
    input wire logic          i_rst_n,
    input wire logic          i_in_valid,
    input ppd_pkg::t_in       i_in_data,
    input wire logic          o_in_stall,
    input wire logic          o_out_valid,
    input ppd_pkg::t_out      o_out_data,
    input wire logic          i_out_stall
);
    import ppd_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("Stalled result transfer changed.");

    a_ref_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && (i_in_data.kind == KIND_REF) |=> o_in_stall)
        else $error("Reference capture did not occupy the block.");

    a_osc_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && (i_in_data.kind == KIND_OSC) |=> !o_in_stall)
        else $error("Oscillator capture occupied the block.");

    a_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_out_data.duty_updated && o_out_data.lock_lost))
        else $error("Result reports both an update and a lock loss.");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("Result valid after reset.");

endmodule

bind pps_phase_pi_discipliner ppd_chk u_ppd_chk (.*);

`default_nettype wire
